// ===== rtl/drt_pkg.sv =====
package drt_pkg;

    localparam int ByteW      = 8;
    localparam int DurationW  = 6;
    localparam int CarryCntW  = 5;
    localparam int CfgIndexW  = 2;
    localparam int CfgDataW   = 8;

    // Counter accumulator: up to 63 << 6 plus 255 needs 13 bits.
    localparam int StepW      = DurationW + 6;
    localparam int CsumW      = StepW + 1;

    localparam logic [CsumW-1:0]     CsumOnce   = 13'h0FF;
    localparam logic [CsumW-1:0]     CsumTwice  = 13'h1FE;
    localparam logic [CarryCntW-1:0] SerialDone = 5'h10;
    localparam logic [ByteW-1:0]     ReloadLow  = 8'd5;
    localparam logic [ByteW-1:0]     ByteMax    = 8'hFF;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_CLR_DIV = 2'd1,
        MODE_WR_CNT  = 2'd2,
        MODE_SERIAL  = 2'd3
    } mode_t;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_TIMER_ENABLE = 2'd0,
        CFG_CLOCK_SELECT = 2'd1,
        CFG_RELOAD_VALUE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [ByteW-1:0] divider;
        logic [ByteW-1:0] counter;
        logic             timer_irq;
        logic             serial_done;
    } result_t;

    // Clock select to counter step: shift 0, 6, 4 or 2.
    function automatic logic [StepW-1:0] counter_step(input logic [1:0] sel,
                                                      input logic [DurationW-1:0] dur);
        logic [StepW-1:0] d;
        d = {{(StepW-DurationW){1'b0}}, dur};
        case (sel)
            2'd0:    counter_step = d;
            2'd1:    counter_step = d << 6;
            2'd2:    counter_step = d << 4;
            default: counter_step = d << 2;
        endcase
    endfunction

endpackage

// ===== rtl/divider_and_reload_timer_top.sv =====
// Emulated console timer. Each transaction on the s_ channel is a tick (duration in
// cycles), a divider clear, a counter write or a serial start, and yields exactly one
// result transaction on the m_ channel carrying the divider and counter bytes and the
// timer interrupt and serial completion flags. A new item is accepted every clock unless
// the skid register is full: the state update is combinational logic feeding the state
// registers and the output stage. A two-entry output stage (result register plus skid
// register) keeps s_ready high while a single result waits for m_ready.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect on the next
// item; indexes beyond the register list are ignored.
module divider_and_reload_timer_top
    import drt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [DurationW-1:0] s_duration,
    input  logic [ByteW-1:0]     s_value,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ByteW-1:0]     m_divider,
    output logic [ByteW-1:0]     m_counter,
    output logic                 m_timer_irq,
    output logic                 m_serial_done
);

    logic                 timer_enable_reg;
    logic [1:0]           clock_select_reg;
    logic [ByteW-1:0]     reload_value_reg;

    logic [ByteW-1:0]     div_prescale_reg,   div_prescale_next;
    logic [ByteW-1:0]     divider_byte_reg,   divider_byte_next;
    logic [ByteW-1:0]     count_prescale_reg, count_prescale_next;
    logic [ByteW-1:0]     counter_byte_reg,   counter_byte_next;
    logic [ByteW-1:0]     last_counter_reg,   last_counter_next;
    logic [CarryCntW-1:0] serial_carries_reg, serial_carries_next;
    logic                 serial_busy_reg,    serial_busy_next;

    result_t              result_next;
    result_t              out_reg;
    result_t              skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;

    logic                 accept;
    logic                 is_tick;
    mode_t                mode;
    logic [ByteW:0]       dsum;
    logic [CsumW-1:0]     csum;
    logic [CarryCntW-1:0] carries_inc;
    logic [ByteW-1:0]     cnt_stepped;
    logic                 irq;
    logic                 done;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign mode    = mode_t'(s_mode);
    assign is_tick = accept && (mode == MODE_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_enable_reg <= 1'b0;
            clock_select_reg <= '0;
            reload_value_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TIMER_ENABLE: timer_enable_reg <= cfg_wdata[0];
                CFG_CLOCK_SELECT: clock_select_reg <= cfg_wdata[1:0];
                CFG_RELOAD_VALUE: reload_value_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        div_prescale_next   = div_prescale_reg;
        divider_byte_next   = divider_byte_reg;
        count_prescale_next = count_prescale_reg;
        counter_byte_next   = counter_byte_reg;
        last_counter_next   = last_counter_reg;
        serial_carries_next = serial_carries_reg;
        serial_busy_next    = serial_busy_reg;
        irq                 = 1'b0;
        done                = 1'b0;

        dsum        = {1'b0, div_prescale_reg} + {1'b0, s_duration, 2'b00};
        csum        = {{(CsumW-ByteW){1'b0}}, count_prescale_reg}
                      + {1'b0, counter_step(clock_select_reg, s_duration)};
        carries_inc = serial_carries_reg + 1'b1;
        cnt_stepped = counter_byte_reg + {7'd0, csum > CsumOnce}
                      + {7'd0, csum > CsumTwice};

        if (accept) begin
            unique case (mode)
                MODE_TICK: begin
                    div_prescale_next = dsum[ByteW-1:0];
                    if (dsum[ByteW]) begin
                        divider_byte_next = divider_byte_reg + 1'b1;
                        if (serial_busy_reg) begin
                            // The transfer completes on the sixteenth divider carry.
                            if (carries_inc == SerialDone) begin
                                serial_carries_next = '0;
                                serial_busy_next    = 1'b0;
                                done                = 1'b1;
                            end else begin
                                serial_carries_next = carries_inc;
                            end
                        end
                    end
                    if (timer_enable_reg) begin
                        count_prescale_next = csum[ByteW-1:0];
                        counter_byte_next   = cnt_stepped;
                        if (cnt_stepped < ReloadLow && last_counter_reg == ByteMax) begin
                            counter_byte_next = reload_value_reg;
                            irq               = 1'b1;
                        end
                        last_counter_next = counter_byte_next;
                    end
                end
                MODE_CLR_DIV: divider_byte_next = '0;
                MODE_WR_CNT:  counter_byte_next = s_value;
                MODE_SERIAL:  serial_busy_next  = 1'b1;
                default: ;
            endcase
        end

        result_next.divider     = divider_byte_next;
        result_next.counter     = counter_byte_next;
        result_next.timer_irq   = irq;
        result_next.serial_done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_prescale_reg   <= '0;
            divider_byte_reg   <= '0;
            count_prescale_reg <= '0;
            counter_byte_reg   <= '0;
            last_counter_reg   <= '0;
            serial_carries_reg <= '0;
            serial_busy_reg    <= 1'b0;
        end else begin
            div_prescale_reg   <= div_prescale_next;
            divider_byte_reg   <= divider_byte_next;
            count_prescale_reg <= count_prescale_next;
            counter_byte_reg   <= counter_byte_next;
            last_counter_reg   <= last_counter_next;
            serial_carries_reg <= serial_carries_next;
            serial_busy_reg    <= serial_busy_next;
        end
    end

    // Output stage: the skid register catches a result when the output register is
    // still held by the downstream side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : result_next;
        end else if (accept) begin
            skid_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_divider     = out_reg.divider;
    assign m_counter     = out_reg.counter;
    assign m_timer_irq   = out_reg.timer_irq;
    assign m_serial_done = out_reg.serial_done;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_carries_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (serial_carries_reg != '0) |-> serial_busy_reg)
        else $error("serial carry count nonzero while no transfer is running");

    a_carries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        serial_carries_reg < SerialDone)
        else $error("serial carry count passed its completion value");

    a_last_tracks_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_tick && timer_enable_reg) |=> (last_counter_reg == counter_byte_reg))
        else $error("last counter value not updated by an enabled tick");

    a_irq_reloads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && irq) |=> (counter_byte_reg == $past(reload_value_reg)))
        else $error("timer interrupt without counter reload");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb
    import drt_pkg::*;
();

    localparam logic [CfgIndexW-1:0] CfgUnused = 2'd3;

    localparam logic [1:0] SelShift0 = 2'd0;
    localparam logic [1:0] SelShift6 = 2'd1;
    localparam logic [1:0] SelShift4 = 2'd2;
    localparam logic [1:0] SelShift2 = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_mode;
    logic [DurationW-1:0] s_duration;
    logic [ByteW-1:0]     s_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [ByteW-1:0]     m_divider;
    logic [ByteW-1:0]     m_counter;
    logic                 m_timer_irq;
    logic                 m_serial_done;

    divider_and_reload_timer_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_duration    (s_duration),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_divider     (m_divider),
        .m_counter     (m_counter),
        .m_timer_irq   (m_timer_irq),
        .m_serial_done (m_serial_done)
    );

    // Timer state mirrored by the predictor.
    logic                 tmr_enable;
    logic [1:0]           tmr_sel;
    logic [ByteW-1:0]     tmr_reload;
    logic [ByteW-1:0]     div_acc;
    logic [ByteW-1:0]     div_count;
    logic [ByteW-1:0]     tmr_acc;
    logic [ByteW-1:0]     tmr_count;
    logic [ByteW-1:0]     tmr_last;
    logic [CarryCntW-1:0] sio_carries;
    logic                 sio_busy;

    result_t timer_outputs_due[$];
    result_t due_output;
    int      error_count;
    int      idle_max;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic result_t predict_timer(mode_t mode, logic [DurationW-1:0] dur,
                                              logic [ByteW-1:0] val);
        logic [ByteW:0]       dsum;
        logic [StepW-1:0]     step;
        logic [CsumW-1:0]     csum;
        result_t              res;
        res = '0;
        case (mode)
            MODE_TICK: begin
                dsum = {1'b0, div_acc} + {1'b0, dur, 2'b00};
                if (dsum > {1'b0, ByteMax}) begin
                    div_count = div_count + 1'b1;
                    if (sio_busy) begin
                        sio_carries = sio_carries + 1'b1;
                        if (sio_carries == SerialDone) begin
                            sio_carries = '0;
                            sio_busy = 1'b0;
                            res.serial_done = 1'b1;
                        end
                    end
                end
                div_acc = dsum[ByteW-1:0];
                if (tmr_enable) begin
                    step = {{(StepW-DurationW){1'b0}}, dur};
                    case (tmr_sel)
                        SelShift0: step = step;
                        SelShift6: step = step << 6;
                        SelShift4: step = step << 4;
                        SelShift2: step = step << 2;
                    endcase
                    csum = {{(CsumW-ByteW){1'b0}}, tmr_acc} + {1'b0, step};
                    if (csum > CsumOnce) tmr_count = tmr_count + 1'b1;
                    if (csum > CsumTwice) tmr_count = tmr_count + 1'b1;
                    tmr_acc = csum[ByteW-1:0];
                    // Overflow is seen as a small count right after the count sat at 0xFF.
                    if (tmr_count < ReloadLow && tmr_last == ByteMax) begin
                        tmr_count = tmr_reload;
                        res.timer_irq = 1'b1;
                    end
                    tmr_last = tmr_count;
                end
            end
            MODE_CLR_DIV: div_count = '0;
            MODE_WR_CNT:  tmr_count = val;
            MODE_SERIAL:  sio_busy = 1'b1;
        endcase
        res.divider = div_count;
        res.counter = tmr_count;
        return res;
    endfunction

    task automatic send_item(mode_t mode, logic [DurationW-1:0] dur, logic [ByteW-1:0] val);
        int gap;
        gap = $urandom_range(0, idle_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_duration <= dur;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        timer_outputs_due.push_back(predict_timer(mode, dur, val));
    endtask

    // Drops valid after the last transaction and waits for every result to drain.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (timer_outputs_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_TIMER_ENABLE: tmr_enable = data[0];
            CFG_CLOCK_SELECT: tmr_sel = data[1:0];
            CFG_RELOAD_VALUE: tmr_reload = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_divider();
        send_item(MODE_TICK, 6'd0, 8'h00);
        send_item(MODE_TICK, 6'd63, 8'hFF);
        send_item(MODE_TICK, 6'd63, 8'h00);
        send_item(MODE_CLR_DIV, 6'd63, 8'hFF);
        send_item(MODE_TICK, 6'd1, 8'h00);
        // The counter is still disabled, so a write sticks but ticks leave it alone.
        send_item(MODE_WR_CNT, 6'd0, 8'hAB);
        send_item(MODE_TICK, 6'd63, 8'h55);
    endtask

    task automatic test_counter_reload();
        write_reg(CFG_TIMER_ENABLE, 8'h01);
        write_reg(CFG_CLOCK_SELECT, 8'h01);
        write_reg(CFG_RELOAD_VALUE, 8'hF0);
        send_item(MODE_WR_CNT, 6'd0, 8'hFD);
        send_item(MODE_TICK, 6'd63, 8'h00);
        send_item(MODE_TICK, 6'd63, 8'h00);
        send_item(MODE_WR_CNT, 6'd0, 8'hFF);
        send_item(MODE_TICK, 6'd63, 8'h00);
        send_item(MODE_WR_CNT, 6'd0, 8'hFD);
        send_item(MODE_TICK, 6'd63, 8'h00);
        // A write does not update the last stored value, so a small write can still reload.
        write_reg(CFG_CLOCK_SELECT, 8'h00);
        send_item(MODE_WR_CNT, 6'd0, 8'h02);
        send_item(MODE_TICK, 6'd0, 8'h00);
    endtask

    task automatic test_serial();
        write_reg(CFG_TIMER_ENABLE, 8'h00);
        send_item(MODE_SERIAL, 6'd0, 8'h00);
        send_item(MODE_SERIAL, 6'd63, 8'hFF);
        repeat (18) send_item(MODE_TICK, 6'd63, 8'h00);
    endtask

    task automatic test_config_masking();
        write_reg(CFG_TIMER_ENABLE, 8'hFE);
        write_reg(CFG_CLOCK_SELECT, 8'hFF);
        write_reg(CfgUnused, 8'hFF);
        send_item(MODE_TICK, 6'd40, 8'h00);
        write_reg(CFG_TIMER_ENABLE, 8'hFF);
        send_item(MODE_TICK, 6'd63, 8'h00);
    endtask

    task automatic test_random_phase(logic en, logic [1:0] sel, logic [ByteW-1:0] reload,
                                     int count);
        int pick;
        logic [DurationW-1:0] dur;
        logic [ByteW-1:0]     val;
        write_reg(CFG_TIMER_ENABLE, {7'($urandom_range(0, 127)), en});
        write_reg(CFG_CLOCK_SELECT, {6'($urandom_range(0, 63)), sel});
        write_reg(CFG_RELOAD_VALUE, reload);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            dur  = DurationW'($urandom_range(0, 63));
            val  = ByteW'($urandom_range(0, 255));
            if (pick < 70) begin
                send_item(MODE_TICK, dur, val);
            end else if (pick < 78) begin
                send_item(MODE_CLR_DIV, dur, val);
            end else if (pick < 90) begin
                // Values near the top make the reload path come up often.
                if ($urandom_range(0, 1)) val = ByteW'($urandom_range(250, 255));
                send_item(MODE_WR_CNT, dur, val);
            end else begin
                send_item(MODE_SERIAL, dur, val);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (timer_outputs_due.size() == 0) begin
                $error("result with nothing expected: divider %0h counter %0h",
                       m_divider, m_counter);
                error_count++;
            end else begin
                due_output = timer_outputs_due.pop_front();
                if (m_divider !== due_output.divider) begin
                    $error("divider: expected %0h, got %0h", due_output.divider, m_divider);
                    error_count++;
                end
                if (m_counter !== due_output.counter) begin
                    $error("counter: expected %0h, got %0h", due_output.counter, m_counter);
                    error_count++;
                end
                if (m_timer_irq !== due_output.timer_irq) begin
                    $error("timer_irq: expected %0b, got %0b", due_output.timer_irq,
                           m_timer_irq);
                    error_count++;
                end
                if (m_serial_done !== due_output.serial_done) begin
                    $error("serial_done: expected %0b, got %0b", due_output.serial_done,
                           m_serial_done);
                    error_count++;
                end
            end
        end
    end

    // Result side: hold m_ready low for a random gap, up to idle_max, before taking each transaction.
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, idle_max);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [ByteW-1:0] reload;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_mode      = MODE_TICK;
        s_duration  = '0;
        s_value     = '0;
        error_count = 0;
        idle_max    = 7;
        tmr_enable  = 1'b0;
        tmr_sel     = '0;
        tmr_reload  = '0;
        div_acc     = '0;
        div_count   = '0;
        tmr_acc     = '0;
        tmr_count   = '0;
        tmr_last    = '0;
        sio_carries = '0;
        sio_busy    = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_divider();
        test_counter_reload();
        test_serial();
        test_config_masking();

        for (int p = 0; p < 8; p++) begin
            idle_max = (p % 3 == 2) ? 0 : 7;
            if (p == 0)
                reload = 8'h00;
            else if (p == 1)
                reload = 8'hFF;
            else
                reload = ByteW'($urandom_range(0, 255));
            test_random_phase(p != 4, p[1:0], reload, 155);
        end

        wait_idle();
        repeat (5) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/drt_pkg.sv
rtl/divider_and_reload_timer_top.sv
verif/tb.sv
